// ===== hw/rtl/rv32i_integer_alu_execute_defines.svh =====
// Assertion macros shared by the RV32I ALU execute block.
// Included by the RTL files that carry concurrent assertions; depends on clk and arst_n.
`ifndef RV32I_INTEGER_ALU_EXECUTE_DEFINES_SVH
`define RV32I_INTEGER_ALU_EXECUTE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define RVALU_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rvalu assertion failed");

// Next-cycle implication, sampled on clk, off while reset is asserted.
`define RVALU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rvalu assertion failed");

`endif

// ===== hw/rtl/rvalu_pkg.sv =====
// Shared types and constants for the RV32I ALU execute block.
// No dependencies; imported by rvalu_alu, the top level and the testbench.
`default_nettype none

package rvalu_pkg;

	localparam int XLEN    = 32;
	localparam int NREGS   = 32;
	localparam int REG_AW  = 5;
	localparam int SHAMT_W = 5;
	localparam int ALT_BIT = 30;

	localparam logic [6:0] OPC_ALUI = 7'h13;
	localparam logic [6:0] OPC_ALU  = 7'h33;

	localparam logic ACT_EXEC  = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	typedef enum logic [2:0] {
		F3_ADD  = 3'd0,
		F3_SLL  = 3'd1,
		F3_SLT  = 3'd2,
		F3_SLTU = 3'd3,
		F3_XOR  = 3'd4,
		F3_SR   = 3'd5,
		F3_OR   = 3'd6,
		F3_AND  = 3'd7
	} funct3_t;

	typedef struct packed {
		logic [REG_AW-1:0] dest_index;
		logic [XLEN-1:0]   dest_value;
		logic              wrote;
		logic              illegal;
	} alu_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rvalu_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module rvalu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rvalu_alu.sv =====
// Instruction decode and ALU for the RV32I execute block, purely combinational.
// Depends on rvalu_pkg; operands arrive already read and forwarded.
`default_nettype none

module rvalu_alu
	import rvalu_pkg::*;
(
	input  wire logic              action,
	input  wire logic [XLEN-1:0]   instruction,
	input  wire logic [REG_AW-1:0] write_index,
	input  wire logic [XLEN-1:0]   write_value,
	input  wire logic [XLEN-1:0]   op_a,
	input  wire logic [XLEN-1:0]   op_b,
	output alu_res_t               res
);

	logic [6:0]         opc;
	logic [REG_AW-1:0]  rd;
	funct3_t            f3;
	logic               alt;
	logic               is_alu;
	logic               is_alui;
	logic [XLEN-1:0]    imm;
	logic [XLEN-1:0]    b;
	logic [SHAMT_W-1:0] shamt;
	logic [XLEN-1:0]    value;

	always_comb begin
		opc     = instruction[6:0];
		rd      = instruction[11:7];
		f3      = funct3_t'(instruction[14:12]);
		alt     = instruction[ALT_BIT];
		is_alu  = (opc == OPC_ALU);
		is_alui = (opc == OPC_ALUI);
		imm     = {{(XLEN-12){instruction[31]}}, instruction[31:20]};
		b       = is_alu ? op_b : imm;
		shamt   = b[SHAMT_W-1:0];

		unique case (f3)
			F3_ADD:  value = (is_alu && alt) ? (op_a - b) : (op_a + b);
			F3_SLL:  value = op_a << shamt;
			F3_SLT:  value = {{(XLEN-1){1'b0}}, ($signed(op_a) < $signed(b))};
			F3_SLTU: value = {{(XLEN-1){1'b0}}, (op_a < b)};
			F3_XOR:  value = op_a ^ b;
			F3_SR:   value = alt ? XLEN'($signed(op_a) >>> shamt) : (op_a >> shamt);
			F3_OR:   value = op_a | b;
			F3_AND:  value = op_a & b;
			default: value = op_a & b;
		endcase

		if (action == ACT_WRITE) begin
			res.dest_index = write_index;
			res.dest_value = write_value;
			res.illegal    = 1'b0;
		end else if (is_alu || is_alui) begin
			res.dest_index = rd;
			res.dest_value = value;
			res.illegal    = 1'b0;
		end else begin
			res.dest_index = '0;
			res.dest_value = '0;
			res.illegal    = 1'b1;
		end
		res.wrote = !res.illegal && (res.dest_index != '0);
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rv32i_integer_alu_execute.sv =====
// Top level of the RV32I ALU execute block: register file RAMs, forwarding and output stage.
// Depends on rvalu_pkg, rvalu_ram, rvalu_alu and rv32i_integer_alu_execute_defines.svh.
//
// Input words arrive on the s_axis channel. tuser is the action: execute the
// instruction in tdata, or write write_value to register write_index. Each word
// gives exactly one result word on m_axis with the destination, its value and the
// wrote and illegal flags.
// The register file lives in two copies of a 32-entry RAM with a registered read, one
// copy per source operand. Operands are read as the word is accepted, and the ALU
// works in the following cycle; the register written by the word just before is
// forwarded from a write-back register.
// A word passes the execute stage register and then the output register on its way to
// m_axis, and one word is taken every cycle while the receiver keeps up.
// When m_axis stalls, the output register holds its word, one more word waits in
// the execute stage with its RAM address held, and s_axis then deasserts tready.
// Reset clears the pipeline and a valid bit per register, so every register reads
// as zero until written; no clearing pass is needed.
`default_nettype none
`include "rv32i_integer_alu_execute_defines.svh"

module rv32i_integer_alu_execute
	import rvalu_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [31:0] instruction, [36:32] write_index, [68:37] write_value, [71:69] zero
	input  wire logic [71:0] s_axis_tdata,
	// [0] action
	input  wire logic [0:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [4:0] dest_index, [36:5] dest_value, [39:37] zero
	output logic      [39:0] m_axis_tdata,
	// [0] wrote, [1] illegal
	output logic      [1:0]  m_axis_tuser
);

	logic              v_s1;
	logic              action_s1;
	logic [XLEN-1:0]   instr_s1;
	logic [REG_AW-1:0] widx_s1;
	logic [XLEN-1:0]   wval_s1;
	logic              adv;
	logic              accept;
	logic [REG_AW-1:0] raddr1;
	logic [REG_AW-1:0] raddr2;
	logic [REG_AW-1:0] rs1_s1;
	logic [REG_AW-1:0] rs2_s1;
	logic [XLEN-1:0]   rdata1;
	logic [XLEN-1:0]   rdata2;
	logic [XLEN-1:0]   op_a;
	logic [XLEN-1:0]   op_b;
	logic [NREGS-1:0]  reg_valid_q;
	logic              wb_v_q;
	logic [REG_AW-1:0] wb_idx_q;
	logic [XLEN-1:0]   wb_val_q;
	logic              ram_we;
	alu_res_t          res;
	logic              out_v_q;
	alu_res_t          out_q;

	assign adv           = v_s1 && (!out_v_q || m_axis_tready);
	assign s_axis_tready = !v_s1 || adv;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign raddr1        = s_axis_tready ? s_axis_tdata[19:15] : rs1_s1;
	assign raddr2        = s_axis_tready ? s_axis_tdata[24:20] : rs2_s1;
	assign rs1_s1        = instr_s1[19:15];
	assign rs2_s1        = instr_s1[24:20];
	assign ram_we        = adv && res.wrote;

	rvalu_ram #(.WIDTH(XLEN), .DEPTH(NREGS)) u_ram_a (
		.clk   (clk),
		.we    (ram_we),
		.waddr (res.dest_index),
		.wdata (res.dest_value),
		.raddr (raddr1),
		.rdata (rdata1)
	);

	rvalu_ram #(.WIDTH(XLEN), .DEPTH(NREGS)) u_ram_b (
		.clk   (clk),
		.we    (ram_we),
		.waddr (res.dest_index),
		.wdata (res.dest_value),
		.raddr (raddr2),
		.rdata (rdata2)
	);

	always_comb begin
		if (rs1_s1 == '0) begin
			op_a = '0;
		end else if (wb_v_q && (wb_idx_q == rs1_s1)) begin
			op_a = wb_val_q;
		end else if (reg_valid_q[rs1_s1]) begin
			op_a = rdata1;
		end else begin
			op_a = '0;
		end
		if (rs2_s1 == '0) begin
			op_b = '0;
		end else if (wb_v_q && (wb_idx_q == rs2_s1)) begin
			op_b = wb_val_q;
		end else if (reg_valid_q[rs2_s1]) begin
			op_b = rdata2;
		end else begin
			op_b = '0;
		end
	end

	rvalu_alu u_alu (
		.action      (action_s1),
		.instruction (instr_s1),
		.write_index (widx_s1),
		.write_value (wval_s1),
		.op_a        (op_a),
		.op_b        (op_b),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_v_q     <= 1'b0;
			wb_v_q      <= 1'b0;
			reg_valid_q <= '0;
		end else begin
			if (s_axis_tready) begin
				v_s1 <= s_axis_tvalid;
			end
			if (adv) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
			if (ram_we) begin
				wb_v_q                       <= 1'b1;
				reg_valid_q[res.dest_index] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= s_axis_tuser[0];
			instr_s1  <= s_axis_tdata[31:0];
			widx_s1   <= s_axis_tdata[36:32];
			wval_s1   <= s_axis_tdata[68:37];
		end
		if (adv) begin
			out_q <= res;
		end
		if (ram_we) begin
			wb_idx_q <= res.dest_index;
			wb_val_q <= res.dest_value;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {3'b000, out_q.dest_value, out_q.dest_index};
	assign m_axis_tuser  = {out_q.illegal, out_q.wrote};

	`RVALU_ASSERT_NOW(a_no_x0_write, ram_we, res.dest_index != '0)
	`RVALU_ASSERT_NEXT(a_wb_tracks_write, ram_we, wb_v_q && reg_valid_q[wb_idx_q])
	`RVALU_ASSERT_NEXT(a_stalled_item_kept, v_s1 && !adv, v_s1)
	`RVALU_ASSERT_NOW(a_illegal_no_write, adv && res.illegal, !ram_we)

endmodule

`default_nettype wire

// ===== verif/rv32i_integer_alu_execute_test.sv =====
// Self-checking testbench for rv32i_integer_alu_execute: a directed table, then random words.
// Every result word is compared against its pinned value or an in-bench RV32I ALU and register file model.
// Depends on rvalu_pkg and the RTL of the block; needs no files or arguments.
module rv32i_integer_alu_execute_test;
	import rvalu_pkg::*;

	localparam int RANDOM_WORDS = 750;
	localparam int MAX_IDLE     = 16;
	localparam int LONG_STALL   = 60;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int PRINT_LIMIT  = 20;

	localparam logic [6:0] F7_BASE  = 7'h00;
	localparam logic [6:0] F7_ALT   = 7'h20;
	localparam logic [6:0] F7_NOISE = 7'h5F;
	localparam logic [6:0] OPC_LUI  = 7'h37;

	typedef struct {
		logic        act;
		logic [31:0] instr;
		logic [4:0]  widx;
		logic [31:0] wval;
		bit          pinned;
		alu_res_t    pinned_res;
	} stim_word_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata;
	logic [0:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	logic [31:0] arch_regs [NREGS];
	alu_res_t    retire_q [$];
	stim_word_t  directed_rows [$];

	bit          cur_pinned;
	alu_res_t    cur_pinned_res;
	bit          no_idle;
	bit          long_stall_req;
	int          mismatches;
	int          cycle_count;
	int          n_exec;
	int          n_write;
	int          n_illegal;
	int          results_checked;

	rv32i_integer_alu_execute dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
			funct3_t f3, logic [4:0] rd);
		return {f7, rs2, rs1, f3, rd, OPC_ALU};
	endfunction

	function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, funct3_t f3,
			logic [4:0] rd);
		return {imm, rs1, f3, rd, OPC_ALUI};
	endfunction

	function automatic stim_word_t exec_word(logic [31:0] instr);
		stim_word_t w;
		w = '{act: ACT_EXEC, instr: instr, widx: '0, wval: '0, pinned: 1'b0, pinned_res: '0};
		return w;
	endfunction

	function automatic stim_word_t write_word(logic [4:0] idx, logic [31:0] val);
		stim_word_t w;
		w = '{act: ACT_WRITE, instr: '0, widx: idx, wval: val, pinned: 1'b0, pinned_res: '0};
		return w;
	endfunction

	function automatic stim_word_t pin(stim_word_t w, logic [4:0] idx, logic [31:0] val,
			logic wrote, logic illegal);
		w.pinned     = 1'b1;
		w.pinned_res = {idx, val, wrote, illegal};
		return w;
	endfunction

	function automatic int idle_gap();
		return no_idle ? 0 : $urandom_range(0, MAX_IDLE);
	endfunction

	function automatic logic [4:0] pick_reg();
		return $urandom_range(0, 1) ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 31));
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return 32'($urandom_range(0, 31));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] read_reg(logic [4:0] idx);
		return (idx == 5'd0) ? 32'd0 : arch_regs[idx];
	endfunction

	function automatic logic [31:0] alu_eval(funct3_t f3, logic alt, logic sub_ok,
			logic [31:0] a, logic [31:0] b);
		logic signed [31:0] sa;
		logic signed [31:0] sb;
		sa = a;
		sb = b;
		case (f3)
			F3_ADD:  return (sub_ok && alt) ? a - b : a + b;
			F3_SLL:  return a << b[SHAMT_W-1:0];
			F3_SLT:  return {31'd0, sa < sb};
			F3_SLTU: return {31'd0, a < b};
			F3_XOR:  return a ^ b;
			F3_SR:   return alt ? 32'(sa >>> b[SHAMT_W-1:0]) : a >> b[SHAMT_W-1:0];
			F3_OR:   return a | b;
			default: return a & b;
		endcase
	endfunction

	// Works out the result word for one accepted input word and retires it into arch_regs.
	function automatic alu_res_t retire_word(logic act, logic [31:0] instr, logic [4:0] widx,
			logic [31:0] wval);
		alu_res_t r;
		funct3_t  f3;
		logic [31:0] a;
		logic [31:0] b;
		r  = '0;
		f3 = funct3_t'(instr[14:12]);
		a  = read_reg(instr[19:15]);
		if (act == ACT_WRITE) begin
			r.dest_index = widx;
			r.dest_value = wval;
		end else if (instr[6:0] == OPC_ALUI) begin
			b = {{20{instr[31]}}, instr[31:20]};
			r.dest_index = instr[11:7];
			r.dest_value = alu_eval(f3, instr[ALT_BIT], 1'b0, a, b);
		end else if (instr[6:0] == OPC_ALU) begin
			b = read_reg(instr[24:20]);
			r.dest_index = instr[11:7];
			r.dest_value = alu_eval(f3, instr[ALT_BIT], 1'b1, a, b);
		end else begin
			r.illegal = 1'b1;
		end
		if (!r.illegal && r.dest_index != 5'd0) begin
			arch_regs[r.dest_index] = r.dest_value;
			r.wrote = 1'b1;
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (mismatches < PRINT_LIMIT)
			$display("mismatch on %s at cycle %0d: got %h, expected %h", what, cycle_count, got,
				want);
		mismatches++;
	endtask

	task automatic send_word(stim_word_t w);
		int gap;
		gap = idle_gap();
		repeat (gap) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid  <= 1'b1;
		s_axis_tuser   <= w.act;
		s_axis_tdata   <= {3'd0, w.wval, w.widx, w.instr};
		cur_pinned     <= w.pinned;
		cur_pinned_res <= w.pinned_res;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	always @(posedge clk) begin : scoreboard
		alu_res_t predicted;
		alu_res_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				predicted = retire_word(s_axis_tuser[0], s_axis_tdata[31:0], s_axis_tdata[36:32],
					s_axis_tdata[68:37]);
				retire_q.push_back(cur_pinned ? cur_pinned_res : predicted);
				if (s_axis_tuser[0] == ACT_WRITE)
					n_write++;
				else if (predicted.illegal)
					n_illegal++;
				else
					n_exec++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (retire_q.size() == 0) begin
					report_mismatch("unexpected result word", m_axis_tdata[36:5], 32'd0);
				end else begin
					want = retire_q.pop_front();
					results_checked++;
					if (m_axis_tdata[4:0] !== want.dest_index)
						report_mismatch("dest_index", 32'(m_axis_tdata[4:0]), 32'(want.dest_index));
					if (m_axis_tdata[36:5] !== want.dest_value)
						report_mismatch("dest_value", m_axis_tdata[36:5], want.dest_value);
					if (m_axis_tuser[0] !== want.wrote)
						report_mismatch("wrote", 32'(m_axis_tuser[0]), 32'(want.wrote));
					if (m_axis_tuser[1] !== want.illegal)
						report_mismatch("illegal", 32'(m_axis_tuser[1]), 32'(want.illegal));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("run timed out after %0d cycles", cycle_count);
			$display("FAILURE");
			$finish;
		end
	end

	initial begin : sink
		int wait_cycles;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_stall_req) begin
				long_stall_req = 1'b0;
				repeat (LONG_STALL) begin
					@(negedge clk);
					m_axis_tready <= 1'b0;
				end
			end
			wait_cycles = idle_gap();
			repeat (wait_cycles) begin
				@(negedge clk);
				m_axis_tready <= 1'b0;
			end
			@(negedge clk);
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	initial begin : source
		stim_word_t  w;
		logic [6:0]  opc;
		logic [6:0]  f7;
		int          kind;
		clk            = 1'b0;
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		s_axis_tuser   = ACT_EXEC;
		cur_pinned     = 1'b0;
		cur_pinned_res = '0;
		no_idle        = 1'b0;
		long_stall_req = 1'b0;
		for (int r = 0; r < NREGS; r++)
			arch_regs[r] = '0;

		directed_rows.push_back(pin(exec_word(enc_r(F7_BASE, 5'd2, 5'd1, F3_ADD, 5'd3)),
			5'd3, 32'd0, 1'b1, 1'b0));
		directed_rows.push_back(pin(write_word(5'd1, 32'hFFFF_FFFF), 5'd1, 32'hFFFF_FFFF, 1'b1, 1'b0));
		directed_rows.push_back(pin(write_word(5'd2, 32'h8000_0000), 5'd2, 32'h8000_0000, 1'b1, 1'b0));
		directed_rows.push_back(pin(write_word(5'd31, 32'h7FFF_FFFF), 5'd31, 32'h7FFF_FFFF, 1'b1,
			1'b0));
		directed_rows.push_back(pin(write_word(5'd0, 32'h1234_5678), 5'd0, 32'h1234_5678, 1'b0, 1'b0));
		directed_rows.push_back(pin(exec_word(32'hFFFF_FFFF), 5'd0, 32'd0, 1'b0, 1'b1));
		directed_rows.push_back(pin(exec_word(32'h0000_0000), 5'd0, 32'd0, 1'b0, 1'b1));
		directed_rows.push_back(pin(exec_word({25'h1FF_FFFF, OPC_LUI}), 5'd0, 32'd0, 1'b0, 1'b1));
		directed_rows.push_back(pin(exec_word(enc_i(12'h800, 5'd0, F3_ADD, 5'd4)),
			5'd4, 32'hFFFF_F800, 1'b1, 1'b0));
		directed_rows.push_back(pin(exec_word(enc_i(12'h7FF, 5'd0, F3_ADD, 5'd5)),
			5'd5, 32'h0000_07FF, 1'b1, 1'b0));
		directed_rows.push_back(exec_word(enc_i(12'h005, 5'd1, F3_ADD, 5'd0)));
		directed_rows.push_back(exec_word(enc_r(F7_BASE, 5'd2, 5'd1, F3_ADD, 5'd6)));
		directed_rows.push_back(exec_word(enc_r(F7_ALT, 5'd1, 5'd2, F3_ADD, 5'd7)));
		directed_rows.push_back(exec_word(enc_r(F7_NOISE, 5'd31, 5'd31, F3_ADD, 5'd8)));
		directed_rows.push_back(exec_word(enc_r(F7_BASE, 5'd31, 5'd1, F3_SLL, 5'd9)));
		directed_rows.push_back(exec_word(enc_r(F7_BASE, 5'd2, 5'd1, F3_SLT, 5'd10)));
		directed_rows.push_back(exec_word(enc_r(F7_BASE, 5'd2, 5'd1, F3_SLTU, 5'd11)));
		directed_rows.push_back(exec_word(enc_r(F7_ALT, 5'd31, 5'd1, F3_XOR, 5'd12)));
		directed_rows.push_back(exec_word(enc_r(F7_BASE, 5'd31, 5'd2, F3_OR, 5'd13)));
		directed_rows.push_back(exec_word(enc_r(F7_BASE, 5'd2, 5'd1, F3_AND, 5'd14)));
		directed_rows.push_back(exec_word(enc_r(F7_BASE, 5'd31, 5'd2, F3_SR, 5'd15)));
		directed_rows.push_back(exec_word(enc_r(F7_ALT, 5'd31, 5'd2, F3_SR, 5'd16)));
		directed_rows.push_back(exec_word(enc_i(12'h41F, 5'd2, F3_SR, 5'd17)));
		directed_rows.push_back(exec_word(enc_i(12'hFE1, 5'd1, F3_SLL, 5'd18)));
		directed_rows.push_back(exec_word(enc_i(12'hFFF, 5'd2, F3_SLTU, 5'd19)));
		directed_rows.push_back(exec_word(enc_i(12'h400, 5'd31, F3_ADD, 5'd20)));

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[k])
			send_word(directed_rows[k]);

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			no_idle = (i >= 100 && i < 180) || (i >= 300 && i < 380);
			if (i == 320)
				long_stall_req = 1'b1;
			if (i == 500) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				while (retire_q.size() != 0)
					@(posedge clk);
			end
			w = exec_word($urandom);
			w.widx = 5'($urandom);
			w.wval = $urandom;
			kind = $urandom_range(0, 9);
			if (kind < 2) begin
				w.act  = ACT_WRITE;
				w.widx = pick_reg();
				w.wval = pick_value();
			end else if (kind == 2) begin
				do opc = 7'($urandom); while (opc == OPC_ALU || opc == OPC_ALUI);
				w.instr[6:0] = opc;
			end else if (kind < 7) begin
				f3_draw: begin
					f7 = ($urandom_range(0, 3) == 0) ? 7'($urandom) :
						($urandom_range(0, 1) ? F7_ALT : F7_BASE);
					w.instr = enc_r(f7, pick_reg(), pick_reg(), funct3_t'($urandom_range(0, 7)),
						pick_reg());
				end
			end else begin
				w.instr = enc_i(12'($urandom), pick_reg(), funct3_t'($urandom_range(0, 7)),
					pick_reg());
			end
			send_word(w);
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (retire_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (retire_q.size() != 0)
			report_mismatch("results still pending", 32'(retire_q.size()), 32'd0);

		$display("Covered %0d words: %0d ALU executes, %0d external writes, %0d illegal opcodes.",
			n_exec + n_write + n_illegal, n_exec, n_write, n_illegal);
		$display("Checked %0d result words in %0d cycles with %0d mismatches.", results_checked,
			cycle_count, mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
